[design/lfia_pkg.sv]
// Shared types and constants for the lowest free identifier allocator.
`timescale 1ns / 1ps

package lfia_pkg;

  localparam int ID_W      = 8;
  localparam int ACT_W     = 2;
  localparam int ST_W      = 2;
  // Flags are stored sixteen entries to a memory word.
  localparam int WORD_BITS = 16;
  localparam int WORD_LG   = 4;
  // Width used for index arithmetic; holds the largest table size plus a word.
  localparam int EXT_W     = 10;
  localparam int ID_LIMIT  = 256;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_BLOCK   = 2'd2,
    ACT_UNBLOCK = 2'd3
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new item and point at its first word
    logic step;    // move the scan to the next word
    logic append;  // point at the word that holds the next new index
    logic commit;  // update the flags and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_alloc;   // latched item is an allocate
    logic appending;  // current word is being read for an append
    logic found;      // current word has a free, unblocked entry
    logic more;       // another existing word follows the current one
    logic room;       // the table can still grow
    logic slot_free;  // the result register can take a result
  } stat_t;

endpackage

[design/lowest_free_id_allocator_top.sv]
// Free, block and unblock read the target's flag word, then commit the result.
// Allocate scans the 16-entry flag words in order from the first, and reads the
// word at the table's end as well when the table grows.
// One item is in work at a time; the single-port flag memory is read one
// 16-entry word at a time. A result waits in its own register.
// Reset clears the entry count and control only; the flags need no clearing.
`timescale 1ns / 1ps

module lowest_free_id_allocator_top #(
  parameter int MAX_IDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] action, [9:2] target_id, [15:10] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] granted_id, [9:8] status, [15:10] zero
);

  lfia_pkg::cmd_t  cmd;
  lfia_pkg::stat_t stat;
  logic [lfia_pkg::ID_W-1:0] granted_id;
  logic [lfia_pkg::ST_W-1:0] status;

  lfia_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  lfia_datapath #(
    .MAX_IDS (MAX_IDS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (s_axis_tdata[1:0]),
    .target_id_i  (s_axis_tdata[9:2]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .granted_id_o (granted_id),
    .status_o     (status)
  );

  assign m_axis_tdata = {6'b0, status, granted_id};

endmodule

[design/lfia_ctrl.sv]
// Controller state machine that sequences reads, scans and commits.
`timescale 1ns / 1ps

module lfia_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  lfia_pkg::stat_t stat_i,
  output lfia_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   finish;

  always_comb begin
    cmd_o         = '0;
    state_d       = state_q;
    s_axis_tready = (state_q == S_IDLE);
    // An item is finished unless an allocate still has words to look at.
    finish = !stat_i.is_alloc || stat_i.appending || stat_i.found ||
             (!stat_i.more && !stat_i.room);
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (finish) begin
          if (stat_i.slot_free) begin
            cmd_o.commit = 1'b1;
            state_d      = S_IDLE;
          end
        end else if (stat_i.more) begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/lfia_datapath.sv]
// Datapath: flag memory, word scan, entry count and result register.
`timescale 1ns / 1ps

module lfia_datapath #(
  parameter int MAX_IDS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lfia_pkg::ACT_W-1:0]    action_i,
  input  logic [lfia_pkg::ID_W-1:0]     target_id_i,
  input  lfia_pkg::cmd_t                cmd_i,
  output lfia_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfia_pkg::ID_W-1:0]     granted_id_o,
  output logic [lfia_pkg::ST_W-1:0]     status_o
);

  localparam int CAP    = (MAX_IDS < lfia_pkg::ID_LIMIT) ? MAX_IDS : lfia_pkg::ID_LIMIT;
  localparam int CNT_W  = $clog2(CAP + 1);
  localparam int NWORDS = (CAP + lfia_pkg::WORD_BITS - 1) / lfia_pkg::WORD_BITS;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int WB     = lfia_pkg::WORD_BITS;
  localparam int EW     = lfia_pkg::EXT_W;
  localparam logic [EW-1:0] CAP_V = EW'(CAP);

  // Each word holds the block bits above the busy bits.
  logic [2*WB-1:0] mem [NWORDS];
  logic [2*WB-1:0] rdata_q;
  logic [2*WB-1:0] wdata;
  logic            we;

  lfia_pkg::action_e            act_q;
  logic [lfia_pkg::ID_W-1:0]    tgt_q;
  logic [WA_W-1:0]              addr_q;
  logic                         append_q;
  logic [CNT_W-1:0]             count_q;
  logic                         out_valid_q;
  logic [lfia_pkg::ID_W-1:0]    granted_q;
  logic [lfia_pkg::ST_W-1:0]    status_q;

  logic [EW-1:0]          cnt_ext;
  logic [EW-1:0]          tgt_ext;
  logic [EW-1:0]          base;
  logic [WB-1:0]          busy;
  logic [WB-1:0]          blocked;
  logic [WB-1:0]          valid;
  logic [WB-1:0]          avail;
  logic [lfia_pkg::WORD_LG-1:0] enc;
  logic [lfia_pkg::WORD_LG-1:0] bit_sel;
  logic                   unknown;
  logic                   slot_free;
  logic [lfia_pkg::ID_W-1:0]    res_id;
  logic [lfia_pkg::ST_W-1:0]    res_st;

  assign cnt_ext   = {{(EW-CNT_W){1'b0}}, count_q};
  assign tgt_ext   = {{(EW-lfia_pkg::ID_W){1'b0}}, tgt_q};
  assign base      = {{(EW-WA_W-lfia_pkg::WORD_LG){1'b0}}, addr_q, {lfia_pkg::WORD_LG{1'b0}}};
  assign busy      = rdata_q[WB-1:0];
  assign blocked   = rdata_q[2*WB-1:WB];
  assign unknown   = (tgt_ext >= cnt_ext);
  assign slot_free = !out_valid_q || out_ready_i;
  assign bit_sel   = tgt_q[lfia_pkg::WORD_LG-1:0];

  // Entries at or above the count were never written and are masked out.
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      valid[b] = ((base + EW'(b)) < cnt_ext);
    end
    avail = ~busy & ~blocked & valid;
    enc   = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (avail[b]) begin
        enc = lfia_pkg::WORD_LG'(b);
      end
    end
  end

  assign stat_o.is_alloc  = (act_q == lfia_pkg::ACT_ALLOC);
  assign stat_o.appending = append_q;
  assign stat_o.found     = |avail;
  assign stat_o.more      = ((base + EW'(WB)) < cnt_ext);
  assign stat_o.room      = (cnt_ext < CAP_V);
  assign stat_o.slot_free = slot_free;

  // Flag update and result for the item being committed.
  always_comb begin
    wdata  = rdata_q;
    we     = 1'b0;
    res_id = '0;
    res_st = lfia_pkg::ST_OK;
    if (act_q == lfia_pkg::ACT_ALLOC) begin
      if (append_q) begin
        wdata[cnt_ext[lfia_pkg::WORD_LG-1:0]]      = 1'b1;
        wdata[WB + cnt_ext[lfia_pkg::WORD_LG-1:0]] = 1'b0;
        we     = 1'b1;
        res_id = cnt_ext[lfia_pkg::ID_W-1:0];
      end else if (|avail) begin
        wdata[enc] = 1'b1;
        we         = 1'b1;
        res_id     = base[lfia_pkg::ID_W-1:0] | {{(lfia_pkg::ID_W-lfia_pkg::WORD_LG){1'b0}}, enc};
      end else begin
        res_st = lfia_pkg::ST_FULL;
      end
    end else if (unknown) begin
      res_st = lfia_pkg::ST_UNKNOWN;
    end else begin
      we = 1'b1;
      case (act_q)
        lfia_pkg::ACT_FREE: begin
          wdata[bit_sel] = 1'b0;
          if (blocked[bit_sel]) begin
            res_st = lfia_pkg::ST_BLOCKED;
          end
        end
        lfia_pkg::ACT_BLOCK: begin
          wdata[WB + bit_sel] = 1'b1;
        end
        default: begin
          wdata[WB + bit_sel] = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      mem[addr_q] <= wdata;
    end
    rdata_q <= mem[addr_q];
  end

  // Latched item and scan position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= lfia_pkg::action_e'(action_i);
      tgt_q    <= target_id_i;
      append_q <= 1'b0;
      if (lfia_pkg::action_e'(action_i) == lfia_pkg::ACT_ALLOC) begin
        addr_q <= '0;
      end else begin
        addr_q <= target_id_i[lfia_pkg::WORD_LG +: WA_W];
      end
    end else if (cmd_i.step) begin
      addr_q <= addr_q + 1'b1;
    end else if (cmd_i.append) begin
      addr_q   <= cnt_ext[lfia_pkg::WORD_LG +: WA_W];
      append_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && (act_q == lfia_pkg::ACT_ALLOC) && append_q) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      granted_q <= res_id;
      status_q  <= res_st;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

endmodule

[verif/lowest_free_id_allocator_top_test.sv]
// Self-checking stream testbench for the lowest free identifier allocator.
`timescale 1ns / 1ps

module lowest_free_id_allocator_top_test;

  localparam int MAX_IDS     = 256;
  localparam int TABLE_CAP   = (MAX_IDS < lfia_pkg::ID_LIMIT) ? MAX_IDS : lfia_pkg::ID_LIMIT;
  localparam int DRAIN_WAIT  = 50;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [lfia_pkg::ID_W-1:0] id;
    lfia_pkg::status_e         st;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [1:0] action, [9:2] target_id, [15:10] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] granted_id, [9:8] status, [15:10] zero

  // Mirror of the allocator table.
  bit     id_busy   [TABLE_CAP];
  bit     id_locked [TABLE_CAP];
  int     table_size;
  reply_t pending_replies[$];

  int fault_count = 0;
  int cycle_count = 0;
  bit idle_off;

  lowest_free_id_allocator_top #(
    .MAX_IDS(MAX_IDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_fault(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  // Works out the reply to one accepted request and updates the table mirror.
  function automatic void apply_request(input lfia_pkg::action_e act,
                                        input logic [lfia_pkg::ID_W-1:0] tgt);
    reply_t r;
    bit     hit;
    r.id = '0;
    r.st = lfia_pkg::ST_OK;
    hit  = 1'b0;
    if (act == lfia_pkg::ACT_ALLOC) begin
      for (int i = 0; i < table_size && !hit; i++) begin
        if (!id_busy[i] && !id_locked[i]) begin
          id_busy[i] = 1'b1;
          r.id       = lfia_pkg::ID_W'(i);
          hit        = 1'b1;
        end
      end
      if (!hit) begin
        if (table_size < TABLE_CAP) begin
          id_busy[table_size]   = 1'b1;
          id_locked[table_size] = 1'b0;
          r.id                  = lfia_pkg::ID_W'(table_size);
          table_size++;
        end else begin
          r.st = lfia_pkg::ST_FULL;
        end
      end
    end else if (int'(tgt) >= table_size) begin
      r.st = lfia_pkg::ST_UNKNOWN;
    end else begin
      case (act)
        lfia_pkg::ACT_FREE: begin
          id_busy[tgt] = 1'b0;
          if (id_locked[tgt]) r.st = lfia_pkg::ST_BLOCKED;
        end
        lfia_pkg::ACT_BLOCK: id_locked[tgt] = 1'b1;
        default:             id_locked[tgt] = 1'b0;
      endcase
    end
    pending_replies = {pending_replies, r};
  endfunction

  // Presents one request and returns at the edge where it is taken.
  task automatic send_request(input lfia_pkg::action_e act,
                              input logic [lfia_pkg::ID_W-1:0] tgt);
    @(negedge clk_i);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, tgt, act};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_request(act, tgt);
  endtask

  task automatic release_bus();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Mostly identifiers that exist, some just past the end, some anywhere.
  function automatic logic [lfia_pkg::ID_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && table_size > 0) begin
      return lfia_pkg::ID_W'($urandom_range(0, table_size - 1));
    end
    if (r == 7) return lfia_pkg::ID_W'(table_size);
    return lfia_pkg::ID_W'($urandom_range(0, 255));
  endfunction

  function automatic lfia_pkg::action_e pick_action(input int alloc_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct) return lfia_pkg::ACT_ALLOC;
    r = $urandom_range(0, 3);
    if (r < 2) return lfia_pkg::ACT_FREE;
    if (r == 2) return lfia_pkg::ACT_BLOCK;
    return lfia_pkg::ACT_UNBLOCK;
  endfunction

  task automatic send_random(input int alloc_pct);
    send_request(pick_action(alloc_pct), pick_target());
  endtask

  task automatic test_directed();
    // Requests against an empty table, then grants, idle and blocked frees.
    send_request(lfia_pkg::ACT_FREE, 8'd0);
    send_request(lfia_pkg::ACT_BLOCK, 8'hFF);
    send_request(lfia_pkg::ACT_UNBLOCK, 8'd0);
    send_request(lfia_pkg::ACT_ALLOC, 8'h00);
    send_request(lfia_pkg::ACT_ALLOC, 8'hAA);
    send_request(lfia_pkg::ACT_ALLOC, 8'h55);
    send_request(lfia_pkg::ACT_FREE, 8'd0);
    send_request(lfia_pkg::ACT_FREE, 8'd0);
    send_request(lfia_pkg::ACT_ALLOC, 8'hFF);
    send_request(lfia_pkg::ACT_BLOCK, 8'd1);
    send_request(lfia_pkg::ACT_FREE, 8'd1);
    // Index one is idle but blocked, so the table has to grow.
    send_request(lfia_pkg::ACT_ALLOC, 8'd1);
    send_request(lfia_pkg::ACT_UNBLOCK, 8'd1);
    send_request(lfia_pkg::ACT_ALLOC, 8'd0);
    send_request(lfia_pkg::ACT_FREE, 8'd4);
    send_request(lfia_pkg::ACT_FREE, 8'd3);
    send_request(lfia_pkg::ACT_BLOCK, 8'd3);
    send_request(lfia_pkg::ACT_UNBLOCK, 8'd3);
    send_request(lfia_pkg::ACT_ALLOC, 8'hFF);
    send_request(lfia_pkg::ACT_UNBLOCK, 8'hFF);
    send_request(lfia_pkg::ACT_BLOCK, 8'd0);
    send_request(lfia_pkg::ACT_FREE, 8'd0);
    send_request(lfia_pkg::ACT_ALLOC, 8'd0);
  endtask

  task automatic test_random_mix();
    repeat (200) send_random(45);
    // Let the allocator go fully idle before carrying on.
    release_bus();
    wait_for_replies();
    repeat (200) send_random(45);
  endtask

  task automatic test_fill_to_capacity();
    int guard;
    guard = 0;
    while (table_size < TABLE_CAP && guard < 700) begin
      send_random(85);
      guard++;
    end
    // Allocation at a full table, interleaved with frees that reopen slots.
    repeat (40) send_random(65);
  endtask

  task automatic test_back_to_back();
    release_bus();
    wait_for_replies();
    idle_off = 1'b1;
    repeat (200) send_random(50);
  endtask

  initial begin : rx_ready_gen
    int stall;
    stall         = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_off) begin
        m_axis_tready = 1'b1;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        stall         = $urandom_range(1, 6) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        flag_fault($sformatf("reply with none pending, data %h", m_axis_tdata));
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata[7:0] !== want.id)
          flag_fault($sformatf("granted_id %0d, want %0d", m_axis_tdata[7:0], want.id));
        if (m_axis_tdata[9:8] !== want.st)
          flag_fault($sformatf("status %0d, want %s", m_axis_tdata[9:8], want.st.name()));
        if (m_axis_tdata[15:10] !== 6'd0)
          flag_fault($sformatf("padding bits %b not zero", m_axis_tdata[15:10]));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    table_size    = 0;
    idle_off      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_mix();
    test_fill_to_capacity();
    test_back_to_back();

    release_bus();
    wait_for_replies();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[lowest_free_id_allocator_top.f]
design/lfia_pkg.sv
design/lfia_ctrl.sv
design/lfia_datapath.sv
design/lowest_free_id_allocator_top.sv
verif/lowest_free_id_allocator_top_test.sv
